@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during rst.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk, quiet during rst.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/rtsdf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package rtsdf_pkg;

  localparam int IMAGE_ROWS_DEF = 64;
  localparam int IMAGE_COLS_DEF = 1024;

  // Epoch tag stored next to each pixel distance
  localparam int TAG_W  = 8;
  localparam int DIST_W = 16;

  // Shared divider widths
  localparam int DIV_N = 53;
  localparam int DIV_D = 33;

  localparam logic [31:0] W32_MAX = 32'hFFFF_FFFF;

  // Register indexes
  localparam logic [2:0] REG_VOX_EDGE      = 3'd0;
  localparam logic [2:0] REG_MIN_RAY       = 3'd1;
  localparam logic [2:0] REG_MAX_RAY       = 3'd2;
  localparam logic [2:0] REG_MAX_WEIGHT    = 3'd3;
  localparam logic [2:0] REG_RAY_DENSITY   = 3'd4;
  localparam logic [2:0] REG_CARVING_ON    = 3'd5;
  localparam logic [2:0] REG_DROPOFF_ON    = 3'd6;
  localparam logic [2:0] REG_SPARSITY_GAIN = 3'd7;

  localparam logic [12:0] RST_VOX_EDGE      = 13'd102;
  localparam logic [15:0] RST_MIN_RAY       = 16'd102;
  localparam logic [15:0] RST_MAX_RAY       = 16'd10240;
  localparam logic [23:0] RST_MAX_WEIGHT    = 24'd2560000;
  localparam logic [31:0] RST_RAY_DENSITY   = 32'd256;
  localparam logic        RST_CARVING_ON    = 1'b1;
  localparam logic        RST_DROPOFF_ON    = 1'b1;
  localparam logic [11:0] RST_SPARSITY_GAIN = 12'd256;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_POINT = 2'd1,
    REQ_VOXEL = 2'd2,
    REQ_RSVD  = 2'd3
  } req_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_CLEAR,
    OP_RES_ZERO,
    OP_RES_SKIP,
    OP_READ,
    OP_PWRITE,
    OP_SDF,
    OP_OW_MAX,
    OP_DIV_RAY,
    OP_OW_RAY,
    OP_DROP_MUL,
    OP_DIV_DROP,
    OP_OW_DROP,
    OP_SPARSE,
    OP_MUL_A,
    OP_MUL_B,
    OP_SUM,
    OP_WEIGHT_ZERO,
    OP_DIV_FUSE,
    OP_FINAL,
    OP_SWEEP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   div_start;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic in_image;
    logic dist_zero;
    logic ray_ok;
    logic d_zero;
    logic hit;
    logic behind;
    logic front_skip;
    logic drop_en;
    logic sparse_en;
    logic nw_zero;
    logic div_done;
    logic sweep_last;
    logic epoch_max;
  } stat_t;

endpackage
`default_nettype wire

@@ rtl/rtsdf_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rtsdf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/rtsdf_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rtsdf_div #(
  parameter int N = 53,
  parameter int D = 33
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [N-1:0] dividend,
  input  wire logic [D-1:0] divisor,
  output logic      [N-1:0] quotient,
  output logic              done
);

  localparam int CW = $clog2(N + 1);

  logic [D-1:0]  rem;
  logic [D-1:0]  dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [D:0]    trial;
  logic [D:0]    diff;
  logic          ge;

  // one quotient bit per cycle, restoring
  assign trial = {rem, quotient[N-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(N);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dvs      <= divisor;
    end else if (busy) begin
      rem      <= ge ? diff[D-1:0] : trial[D-1:0];
      quotient <= {quotient[N-2:0], ge};
    end
  end

endmodule
`default_nettype wire

@@ rtl/rtsdf_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rtsdf_dp import rtsdf_pkg::*; #(
  parameter int IMAGE_ROWS = IMAGE_ROWS_DEF,
  parameter int IMAGE_COLS = IMAGE_COLS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  output stat_t                   stat,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic [1:0]         req_type,
  input  wire logic [5:0]         pixel_row,
  input  wire logic [9:0]         pixel_col,
  input  wire logic [15:0]        point_distance,
  input  wire logic [15:0]        voxel_distance,
  input  wire logic signed [14:0] old_tsdf,
  input  wire logic [23:0]        old_weight,
  output logic signed [14:0]      new_tsdf,
  output logic [23:0]             new_weight,
  output logic                    voxel_updated,
  output logic                    pixel_written
);

  localparam int PIXELS = IMAGE_ROWS * IMAGE_COLS;
  localparam int AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int MW     = TAG_W + DIST_W;

  // configuration
  logic [12:0] vox_edge;
  logic [15:0] min_ray, max_ray;
  logic [23:0] max_weight_cap;
  logic [31:0] ray_density;
  logic        carving_on, dropoff_on;
  logic [11:0] sparsity_gain;

  // latched item
  req_t               typ;
  logic [5:0]         row;
  logic [9:0]         col;
  logic [15:0]        pdist, vdist;
  logic signed [14:0] old_t;
  logic [23:0]        old_w;

  logic [TAG_W-1:0]   epoch;
  logic [AW-1:0]      sweep_cnt;
  logic signed [17:0] sdf;
  logic [31:0]        ow;
  logic [44:0]        prod;
  logic signed [39:0] p1;
  logic signed [50:0] p2;
  logic [23:0]        nw;
  logic [50:0]        mag;
  logic               neg;

  logic [31:0]        lin;
  logic [AW-1:0]      addr;
  logic [MW-1:0]      rdata;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [MW-1:0]      ram_wdata;
  logic               hit;
  logic               replace;
  logic [15:0]        spix;

  logic signed [17:0] t_s, v_s;
  logic [17:0]        tsum;
  logic [43:0]        sp_prod;
  logic [35:0]        sp_shift;
  logic [32:0]        wsum;
  logic signed [17:0] clip;
  logic signed [51:0] num;
  logic [DIV_N-1:0]   div_dividend;
  logic [DIV_D-1:0]   div_divisor;
  logic [DIV_N-1:0]   quo;
  logic               div_done;
  logic [31:0]        dsq;

  assign lin  = 32'(row) * 32'(IMAGE_COLS) + 32'(col);
  assign addr = lin[AW-1:0];
  assign spix = rdata[DIST_W-1:0];
  assign hit  = rdata[MW-1:DIST_W] == epoch;
  assign replace = !hit || (spix > pdist);

  assign t_s  = signed'({4'b0, vox_edge, 1'b0});
  assign v_s  = signed'({5'b0, vox_edge});
  assign tsum = 18'(t_s + sdf);
  assign clip = (sdf < t_s) ? sdf : t_s;
  assign sp_prod  = ow * sparsity_gain;
  assign sp_shift = sp_prod[43:8];
  assign wsum = {9'b0, old_w} + {1'b0, ow};
  assign num  = 52'(p1) + 52'(p2);
  assign dsq  = vdist * vdist;

  always_comb begin
    stat.req        = typ;
    stat.in_image   = (32'(row) < 32'(IMAGE_ROWS)) && (32'(col) < 32'(IMAGE_COLS));
    stat.dist_zero  = pdist == 16'd0;
    stat.ray_ok     = (vdist >= min_ray) && (vdist <= max_ray);
    stat.d_zero     = vdist == 16'd0;
    stat.hit        = hit;
    stat.behind     = sdf < -t_s;
    stat.front_skip = !carving_on && (sdf > t_s);
    stat.drop_en    = dropoff_on && (sdf < -v_s) && (vox_edge != 13'd0);
    stat.sparse_en  = (sdf < t_s) && (sdf > -t_s);
    stat.nw_zero    = nw == 24'd0;
    stat.div_done   = div_done;
    stat.sweep_last = sweep_cnt == AW'(PIXELS - 1);
    stat.epoch_max  = &epoch;
  end

  // divider operand select
  always_comb begin
    div_dividend = '0;
    div_divisor  = '0;
    unique case (cmd.op)
      OP_DIV_RAY: begin
        div_dividend = {1'b0, ray_density, 20'b0};
        div_divisor  = {1'b0, dsq};
      end
      OP_DIV_DROP: begin
        div_dividend = DIV_N'(prod);
        div_divisor  = DIV_D'(vox_edge);
      end
      OP_DIV_FUSE: begin
        div_dividend = DIV_N'({mag, 1'b0}) + DIV_N'(nw);
        div_divisor  = DIV_D'({nw, 1'b0});
      end
      default: begin
        div_dividend = '0;
        div_divisor  = '0;
      end
    endcase
  end

  rtsdf_div #(.N(DIV_N), .D(DIV_D)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (quo),
    .done     (div_done)
  );

  assign ram_we    = (cmd.op == OP_SWEEP) || ((cmd.op == OP_PWRITE) && replace);
  assign ram_waddr = (cmd.op == OP_SWEEP) ? sweep_cnt : addr;
  assign ram_wdata = (cmd.op == OP_SWEEP) ? '0 : {epoch, pdist};

  rtsdf_ram #(.WIDTH(MW), .DEPTH(PIXELS), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.op == OP_READ),
    .raddr (addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vox_edge       <= RST_VOX_EDGE;
      min_ray        <= RST_MIN_RAY;
      max_ray        <= RST_MAX_RAY;
      max_weight_cap <= RST_MAX_WEIGHT;
      ray_density    <= RST_RAY_DENSITY;
      carving_on     <= RST_CARVING_ON;
      dropoff_on     <= RST_DROPOFF_ON;
      sparsity_gain  <= RST_SPARSITY_GAIN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VOX_EDGE:      vox_edge       <= cfg_data[12:0];
        REG_MIN_RAY:       min_ray        <= cfg_data[15:0];
        REG_MAX_RAY:       max_ray        <= cfg_data[15:0];
        REG_MAX_WEIGHT:    max_weight_cap <= cfg_data[23:0];
        REG_RAY_DENSITY:   ray_density    <= cfg_data;
        REG_CARVING_ON:    carving_on     <= cfg_data[0];
        REG_DROPOFF_ON:    dropoff_on     <= cfg_data[0];
        REG_SPARSITY_GAIN: sparsity_gain  <= cfg_data[11:0];
      endcase
    end
  end

  // epoch and clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      epoch     <= TAG_W'(1);
      sweep_cnt <= '0;
    end else if (cmd.op == OP_CLEAR) begin
      epoch <= epoch + 1'b1;
    end else if (cmd.op == OP_SWEEP) begin
      if (stat.sweep_last) begin
        sweep_cnt <= '0;
        epoch     <= TAG_W'(1);
      end else begin
        sweep_cnt <= sweep_cnt + 1'b1;
      end
    end
  end

  // item and arithmetic registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LATCH: begin
        typ   <= req_t'(req_type);
        row   <= pixel_row;
        col   <= pixel_col;
        pdist <= point_distance;
        vdist <= voxel_distance;
        old_t <= old_tsdf;
        old_w <= old_weight;
      end
      OP_SDF:      sdf  <= signed'({2'b0, spix}) - signed'({2'b0, vdist});
      OP_OW_MAX:   ow   <= W32_MAX;
      OP_OW_RAY:   ow   <= (|quo[DIV_N-1:32]) ? W32_MAX : quo[31:0];
      OP_DROP_MUL: prod <= ow * tsum[12:0];
      OP_OW_DROP:  ow   <= quo[31:0];
      OP_SPARSE:   ow   <= (|sp_shift[35:32]) ? W32_MAX : sp_shift[31:0];
      OP_MUL_A: begin
        p1 <= old_t * signed'({1'b0, old_w});
        nw <= (wsum > {9'b0, max_weight_cap}) ? max_weight_cap : wsum[23:0];
      end
      OP_MUL_B: p2 <= clip * signed'({1'b0, ow});
      OP_SUM: begin
        neg <= num[51];
        mag <= num[51] ? 51'(-num) : num[50:0];
      end
      default: ;
    endcase
  end

  // result registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_CLEAR, OP_RES_ZERO, OP_SWEEP: begin
        new_tsdf      <= '0;
        new_weight    <= '0;
        voxel_updated <= 1'b0;
        pixel_written <= 1'b0;
      end
      OP_RES_SKIP: begin
        new_tsdf      <= old_t;
        new_weight    <= old_w;
        voxel_updated <= 1'b0;
        pixel_written <= 1'b0;
      end
      OP_PWRITE: begin
        new_tsdf      <= '0;
        new_weight    <= '0;
        voxel_updated <= 1'b0;
        pixel_written <= replace;
      end
      OP_WEIGHT_ZERO: begin
        new_tsdf      <= old_t;
        new_weight    <= '0;
        voxel_updated <= 1'b1;
        pixel_written <= 1'b0;
      end
      OP_FINAL: begin
        if (neg) begin
          new_tsdf <= (quo > DIV_N'(16384)) ? -15'sd16384 : 15'(-quo[14:0]);
        end else begin
          new_tsdf <= (quo > DIV_N'(16383)) ? 15'sd16383 : quo[14:0];
        end
        new_weight    <= nw;
        voxel_updated <= 1'b1;
        pixel_written <= 1'b0;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/rtsdf_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rtsdf_ctrl import rtsdf_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire stat_t stat,
  output cmd_t       cmd,
  output logic       busy,
  output logic       done
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_EVAL, S_CHECK, S_DIV_RAY, S_DROP, S_DROP_GO,
    S_DIV_DROP, S_SPARSE, S_MUL_A, S_MUL_B, S_SUM, S_FUSE_GO, S_DIV_FUSE,
    S_SWEEP
  } state_t;

  state_t state, state_next;
  logic   pend;
  logic   fin;

  assign busy = state != S_IDLE;

  always_comb begin
    state_next    = state;
    cmd.op        = OP_NONE;
    cmd.div_start = 1'b0;
    fin           = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op     = OP_LATCH;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.req)
          REQ_CLEAR: begin
            if (stat.epoch_max) begin
              state_next = S_SWEEP;
            end else begin
              cmd.op = OP_CLEAR;
              fin    = 1'b1;
            end
          end
          REQ_POINT: begin
            if (stat.dist_zero || !stat.in_image) begin
              cmd.op = OP_RES_ZERO;
              fin    = 1'b1;
            end else begin
              cmd.op     = OP_READ;
              state_next = S_EVAL;
            end
          end
          REQ_VOXEL: begin
            if (!stat.ray_ok || !stat.in_image) begin
              cmd.op = OP_RES_SKIP;
              fin    = 1'b1;
            end else begin
              cmd.op     = OP_READ;
              state_next = S_EVAL;
            end
          end
          REQ_RSVD: begin
            cmd.op = OP_RES_ZERO;
            fin    = 1'b1;
          end
        endcase
      end
      S_EVAL: begin
        if (stat.req == REQ_POINT) begin
          cmd.op = OP_PWRITE;
          fin    = 1'b1;
        end else if (!stat.hit) begin
          cmd.op = OP_RES_SKIP;
          fin    = 1'b1;
        end else begin
          cmd.op     = OP_SDF;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.behind || stat.front_skip) begin
          cmd.op = OP_RES_SKIP;
          fin    = 1'b1;
        end else if (stat.d_zero) begin
          cmd.op     = OP_OW_MAX;
          state_next = S_DROP;
        end else begin
          cmd.op        = OP_DIV_RAY;
          cmd.div_start = 1'b1;
          state_next    = S_DIV_RAY;
        end
      end
      S_DIV_RAY: begin
        if (stat.div_done) begin
          cmd.op     = OP_OW_RAY;
          state_next = S_DROP;
        end
      end
      S_DROP: begin
        if (stat.drop_en) begin
          cmd.op     = OP_DROP_MUL;
          state_next = S_DROP_GO;
        end else begin
          state_next = S_SPARSE;
        end
      end
      S_DROP_GO: begin
        cmd.op        = OP_DIV_DROP;
        cmd.div_start = 1'b1;
        state_next    = S_DIV_DROP;
      end
      S_DIV_DROP: begin
        if (stat.div_done) begin
          cmd.op     = OP_OW_DROP;
          state_next = S_SPARSE;
        end
      end
      S_SPARSE: begin
        if (stat.sparse_en) begin
          cmd.op = OP_SPARSE;
        end
        state_next = S_MUL_A;
      end
      S_MUL_A: begin
        cmd.op     = OP_MUL_A;
        state_next = S_MUL_B;
      end
      S_MUL_B: begin
        cmd.op     = OP_MUL_B;
        state_next = S_SUM;
      end
      S_SUM: begin
        if (stat.nw_zero) begin
          cmd.op = OP_WEIGHT_ZERO;
          fin    = 1'b1;
        end else begin
          cmd.op     = OP_SUM;
          state_next = S_FUSE_GO;
        end
      end
      S_FUSE_GO: begin
        cmd.op        = OP_DIV_FUSE;
        cmd.div_start = 1'b1;
        state_next    = S_DIV_FUSE;
      end
      S_DIV_FUSE: begin
        if (stat.div_done) begin
          cmd.op = OP_FINAL;
          fin    = 1'b1;
        end
      end
      S_SWEEP: begin
        cmd.op = OP_SWEEP;
        if (stat.sweep_last) begin
          state_next = S_IDLE;
          fin        = pend;
        end
      end
    endcase
    if (fin) begin
      state_next = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
      if (state == S_DECODE && state_next == S_SWEEP) begin
        pend <= 1'b1;
      end else if (state == S_SWEEP && stat.sweep_last) begin
        pend <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/range_image_tsdf_fusion.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Range-image TSDF fusion. An item is taken when start is high and busy is low;
// its single result appears on the result ports for one cycle with done high,
// and the receiver cannot stall it, so capture it on that cycle. An applied voxel
// update runs the one shared bit-serial divider up to three times (ray weight,
// weight drop-off, weighted average), each pass holding the sequence until the
// divider is done; the ray weight pass is skipped for a voxel at distance zero,
// the drop-off pass when drop-off does not apply, and the average when the new
// weight is zero. The pixel store is one RAM with an epoch tag per pixel; a
// clear bumps the epoch. After reset, and on the clear that wraps the 8-bit
// epoch, a clearing pass writes every pixel once, with busy high. Configuration
// writes land at once; the user must make them only while idle, which the
// block itself does not enforce.
module range_image_tsdf_fusion import rtsdf_pkg::*; #(
  parameter int IMAGE_ROWS = IMAGE_ROWS_DEF,
  parameter int IMAGE_COLS = IMAGE_COLS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         req_type,
  input  wire logic [5:0]         pixel_row,
  input  wire logic [9:0]         pixel_col,
  input  wire logic [15:0]        point_distance,
  input  wire logic [15:0]        voxel_distance,
  input  wire logic signed [14:0] old_tsdf,
  input  wire logic [23:0]        old_weight,
  output logic                    done,
  output logic signed [14:0]      new_tsdf,
  output logic [23:0]             new_weight,
  output logic                    voxel_updated,
  output logic                    pixel_written,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  // sequencing: one item at a time, steps driven by the controller
  rtsdf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // pixel store, divider, multipliers and result registers
  rtsdf_dp #(.IMAGE_ROWS(IMAGE_ROWS), .IMAGE_COLS(IMAGE_COLS)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .req_type       (req_type),
    .pixel_row      (pixel_row),
    .pixel_col      (pixel_col),
    .point_distance (point_distance),
    .voxel_distance (voxel_distance),
    .old_tsdf       (old_tsdf),
    .old_weight     (old_weight),
    .new_tsdf       (new_tsdf),
    .new_weight     (new_weight),
    .voxel_updated  (voxel_updated),
    .pixel_written  (pixel_written)
  );

endmodule
`default_nettype wire

@@ rtl/rtsdf_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rtsdf_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire logic voxel_updated,
  input wire logic pixel_written
);

  `ASSERT_SAME(a_done_idle, done, !busy)
  `ASSERT_NEXT(a_take_busy, start && !busy, busy)
  `ASSERT_NEXT(a_done_pulse, done, !done)
  `ASSERT_SAME(a_flags_excl, done, !(voxel_updated && pixel_written))

endmodule

bind range_image_tsdf_fusion rtsdf_checker u_chk (.*);
`default_nettype wire

@@ tb/tb_range_image_tsdf_fusion.sv @@
`timescale 1ns / 1ps
module tb_range_image_tsdf_fusion;
  import rtsdf_pkg::*;

  localparam int  NPIX      = 65536;
  localparam longint LIMIT  = 3000000;  // sweeps, slow updates and gaps, several times over
  localparam int  SETTLE    = 250;      // longest applied voxel update plus margin

  typedef struct {
    logic [1:0]         req;
    logic [5:0]         row;
    logic [9:0]         col;
    logic [15:0]        pdist;
    logic [15:0]        vdist;
    logic signed [14:0] otsdf;
    logic [23:0]        oweight;
  } fuse_req_t;

  typedef struct {
    logic signed [14:0] tsdf;
    logic [23:0]        weight;
    logic               vu;
    logic               pw;
  } fuse_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  logic [1:0]         req_type = '0;
  logic [5:0]         pixel_row = '0;
  logic [9:0]         pixel_col = '0;
  logic [15:0]        point_distance = '0;
  logic [15:0]        voxel_distance = '0;
  logic signed [14:0] old_tsdf = '0;
  logic [23:0]        old_weight = '0;
  logic signed [14:0] new_tsdf;
  logic [23:0]        new_weight;
  logic               voxel_updated, pixel_written;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  range_image_tsdf_fusion uut (.*);

  always #5 clk = ~clk;

  // Shadow copy of the block: range image, valid bits and registers.
  logic [15:0] range_img [NPIX];
  bit          range_ok  [NPIX];
  longint      sh_vox, sh_minr, sh_maxr, sh_cap, sh_dens, sh_carve, sh_drop, sh_gain;

  fuse_req_t pending_q[$];
  fuse_res_t fused_q[$];
  int        sent_n = 0, acc_n = 0, idle_cnt = 0;
  bit        idle_on = 1'b1;
  int        errors = 0, results_n = 0, applied_n = 0, written_n = 0;
  longint    cyc = 0;

  // Pixel pool for well-formed write-then-update sequences.
  logic [5:0]  pool_row [16];
  logic [9:0]  pool_col [16];
  int          pool_dist[16];

  function automatic fuse_res_t fuse_predict(fuse_req_t it);
    fuse_res_t r;
    int     idx;
    longint d, sdf, t, ow, nw, clip, num, mag, q, ot;
    r = '{default: '0};
    idx = int'({it.row, it.col});
    if (it.req == REQ_CLEAR) begin
      foreach (range_ok[i]) range_ok[i] = 1'b0;
    end else if (it.req == REQ_POINT) begin
      if (it.pdist != 0 && (!range_ok[idx] || range_img[idx] > it.pdist)) begin
        range_img[idx] = it.pdist;
        range_ok[idx] = 1'b1;
        r.pw = 1'b1;
      end
    end else if (it.req == REQ_VOXEL) begin
      r.tsdf = it.otsdf;
      r.weight = it.oweight;
      d = it.vdist;
      ot = it.otsdf;
      t = 2 * sh_vox;
      if (d < sh_minr || d > sh_maxr || !range_ok[idx]) return r;
      sdf = longint'(range_img[idx]) - d;
      if (sdf < -t) return r;
      if (!sh_carve && sdf > t) return r;
      if (d == 0) ow = 64'hFFFF_FFFF;
      else ow = (sh_dens << 20) / (d * d);
      if (ow > 64'hFFFF_FFFF) ow = 64'hFFFF_FFFF;
      if (sh_drop && sdf < -sh_vox && sh_vox > 0) ow = ow * (t + sdf) / sh_vox;
      if (sdf < t && sdf > -t) begin
        ow = (ow * sh_gain) >>> 8;
        if (ow > 64'hFFFF_FFFF) ow = 64'hFFFF_FFFF;
      end
      nw = longint'(it.oweight) + ow;
      if (nw > sh_cap) nw = sh_cap;
      r.vu = 1'b1;
      r.weight = nw[23:0];
      if (nw == 0) return r;
      clip = (sdf < t) ? sdf : t;
      num = ot * longint'(it.oweight) + clip * ow;
      mag = (num < 0) ? -num : num;
      mag = (2 * mag + nw) / (2 * nw);
      q = (num < 0) ? -mag : mag;
      if (q < -16384) q = -16384;
      if (q > 16383) q = 16383;
      r.tsdf = q[14:0];
    end
    return r;
  endfunction

  // Accept side: predict each transaction in order of acceptance.
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      fuse_req_t it;
      it = '{req_type, pixel_row, pixel_col, point_distance, voxel_distance,
             old_tsdf, old_weight};
      fused_q = {fused_q, fuse_predict(it)};
      acc_n <= acc_n + 1;
    end
  end

  // Result side: one strobe per transaction, compared with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (fused_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        fuse_res_t e;
        e = fused_q.pop_front();
        results_n++;
        if (e.vu) applied_n++;
        if (e.pw) written_n++;
        if (new_tsdf !== e.tsdf) begin
          $error("new_tsdf expected %0d got %0d", e.tsdf, new_tsdf); errors++;
        end
        if (new_weight !== e.weight) begin
          $error("new_weight expected %0d got %0d", e.weight, new_weight); errors++;
        end
        if (voxel_updated !== e.vu) begin
          $error("voxel_updated expected %0b got %0b", e.vu, voxel_updated); errors++;
        end
        if (pixel_written !== e.pw) begin
          $error("pixel_written expected %0b got %0b", e.pw, pixel_written); errors++;
        end
      end
    end
  end

  // Driver: hold a transaction until accepted, then advance or idle a burst.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && sent_n != acc_n) begin
      start <= 1'b1;
    end else if (idle_cnt > 0) begin
      idle_cnt <= idle_cnt - 1;
      start <= 1'b0;
    end else if (pending_q.size() > 0) begin
      fuse_req_t it;
      it = pending_q.pop_front();
      req_type <= it.req;
      pixel_row <= it.row;
      pixel_col <= it.col;
      point_distance <= it.pdist;
      voxel_distance <= it.vdist;
      old_tsdf <= it.otsdf;
      old_weight <= it.oweight;
      start <= 1'b1;
      sent_n <= sent_n + 1;
      if (idle_on && $urandom_range(0, 3) == 0) idle_cnt <= int'($urandom_range(1, 8));
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT) begin
      $display("tb_range_image_tsdf_fusion NOT OK");
      $finish;
    end
  end

  task automatic push(logic [1:0] rq, int row, int col, int pd, int vd, int ot, int ow);
    fuse_req_t it;
    it = '{rq, row[5:0], col[9:0], pd[15:0], vd[15:0], ot[14:0], ow[23:0]};
    pending_q = {pending_q, it};
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_VOX_EDGE:      sh_vox   = longint'(val[12:0]);
      REG_MIN_RAY:       sh_minr  = longint'(val[15:0]);
      REG_MAX_RAY:       sh_maxr  = longint'(val[15:0]);
      REG_MAX_WEIGHT:    sh_cap   = longint'(val[23:0]);
      REG_RAY_DENSITY:   sh_dens  = longint'(val);
      REG_CARVING_ON:    sh_carve = longint'(val[0]);
      REG_DROPOFF_ON:    sh_drop  = longint'(val[0]);
      REG_SPARSITY_GAIN: sh_gain  = longint'(val[11:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic cfg_all(int vx, int mn, int mx, int cap, logic [31:0] dens, int cv,
                         int dr, int gn);
    cfg_write(REG_VOX_EDGE, vx);
    cfg_write(REG_MIN_RAY, mn);
    cfg_write(REG_MAX_RAY, mx);
    cfg_write(REG_MAX_WEIGHT, cap);
    cfg_write(REG_RAY_DENSITY, dens);
    cfg_write(REG_CARVING_ON, cv);
    cfg_write(REG_DROPOFF_ON, dr);
    cfg_write(REG_SPARSITY_GAIN, gn);
  endtask

  // Wait for every queued transaction and result, then let the block settle.
  task automatic drain();
    wait (pending_q.size() == 0 && sent_n == acc_n && fused_q.size() == 0);
    repeat (SETTLE) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  // Mostly voxel updates around the written distance, with point writes,
  // a few clears and fully random noise transactions.
  task automatic add_random(int n);
    int k, p, t, off, vd, pd;
    for (int i = 0; i < n; i++) begin
      k = int'($urandom_range(0, 99));
      p = int'($urandom_range(0, 15));
      t = int'(2 * sh_vox);
      if (k < 3) begin
        push(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (k < 12) begin
        push(2'($urandom_range(REQ_POINT, REQ_RSVD)), $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom);
      end else if (k < 35) begin
        pd = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 65535))
                                          : int'($urandom_range(64, 12000));
        if (pd != 0 && pd < pool_dist[p]) pool_dist[p] = pd;
        if ($urandom_range(0, 3) == 0) pool_dist[p] = pd;
        push(REQ_POINT, pool_row[p], pool_col[p], pd, $urandom, $urandom, $urandom);
      end else begin
        off = int'($urandom_range(0, 6 * t + 2)) - 3 * t - 1;
        vd = pool_dist[p] - off;
        if (vd < 0) vd = 0;
        if (vd > 65535) vd = 65535;
        if (vd == 0 && $urandom_range(0, 3) != 0) vd = 1;
        push(REQ_VOXEL, pool_row[p], pool_col[p], $urandom, vd,
             $urandom_range(0, 32767), ($urandom_range(0, 3) == 0) ? 0 : $urandom);
      end
    end
  endtask

  initial begin
    sh_vox = 102; sh_minr = 102; sh_maxr = 10240; sh_cap = 2560000;
    sh_dens = 256; sh_carve = 1; sh_drop = 1; sh_gain = 256;
    foreach (range_ok[i]) range_ok[i] = 1'b0;
    for (int i = 0; i < 16; i++) begin
      pool_row[i] = 6'($urandom);
      pool_col[i] = 10'($urandom);
      pool_dist[i] = 3000;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (busy) @(negedge clk);  // clearing pass after reset

    // Directed: field extremes, each request kind and most skip paths.
    push(REQ_VOXEL, 0, 0, 1, 2000, 100, 500);            // empty pixel
    push(REQ_POINT, 0, 0, 0, 0, 0, 0);                    // zero distance ignored
    push(REQ_POINT, 0, 0, 2000, 0, 0, 0);
    push(REQ_POINT, 0, 0, 2000, 0, 0, 0);                 // equal, not replaced
    push(REQ_POINT, 0, 0, 2500, 0, 0, 0);                 // farther, not replaced
    push(REQ_POINT, 63, 1023, 65535, 65535, -1, 24'hFFFFFF);
    push(REQ_POINT, 63, 1023, 1000, 0, 0, 0);             // nearer, replaced
    push(REQ_VOXEL, 0, 0, 0, 1990, 0, 0);                 // inside band
    push(REQ_VOXEL, 0, 0, 0, 2300, -16384, 24'hFFFFFF);   // behind band
    push(REQ_VOXEL, 0, 0, 0, 2150, 16383, 1000);          // drop-off zone
    push(REQ_VOXEL, 0, 0, 0, 1500, 300, 256);             // in front, carving
    push(REQ_VOXEL, 0, 0, 0, 101, 0, 0);                  // below min ray
    push(REQ_VOXEL, 0, 0, 0, 10241, 0, 0);                // beyond max ray
    push(REQ_VOXEL, 63, 1023, 0, 1000, -16384, 0);        // on the surface
    push(REQ_RSVD, 63, 1023, 65535, 65535, -1, 24'hFFFFFF);
    push(REQ_CLEAR, 0, 0, 0, 0, 0, 0);
    push(REQ_VOXEL, 0, 0, 0, 2000, 5, 5);                 // cleared pixel
    push(REQ_POINT, 0, 0, 2000, 0, 0, 0);                 // rewrite after clear
    push(REQ_VOXEL, 0, 0, 0, 2000, 16383, 24'h7FFFFF);
    add_random(180);
    drain();

    // A wide truncation band, all limits open, carving and drop-off off.
    cfg_all(4096, 0, 65535, 16777215, 32'hFFFF_FFFF, 0, 0, 4095);
    add_random(190);
    drain();

    // Narrowest voxel, unit weight cap, no ray weight.
    cfg_all(1, 0, 65535, 1, 0, 1, 1, 0);
    add_random(190);
    drain();

    // Random settings, zero cap allowed.
    cfg_all($urandom_range(1, 4096), $urandom_range(0, 200), $urandom_range(8000, 65535),
            ($urandom_range(0, 1) ? 0 : $urandom_range(1, 16777215)), $urandom,
            $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 4095));
    add_random(190);
    drain();

    // Back to the reset values, no idling.
    cfg_all(102, 102, 10240, 2560000, 256, 1, 1, 256);
    idle_on = 1'b0;
    add_random(190);
    drain();

    $display("Covered %0d transactions: %0d voxel updates applied, %0d pixels written,",
             results_n, applied_n, written_n);
    $display("over five register settings including both extremes.");
    if (errors == 0) $display("tb_range_image_tsdf_fusion OK");
    else $display("tb_range_image_tsdf_fusion NOT OK");
    $finish;
  end

endmodule
